>>> src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants and controller/datapath interface types for the deque.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LIST_FWD   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_LIST_REV   = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch incoming transaction, clear list index
        logic commit;    // apply push/pop to pointers and store
        logic rd_en;     // read store at current ring position
        logic load_imm;  // load result: status only, data zero, last set
        logic load_mem;  // load result from store read data
        logic idx_inc;   // advance list index
    } dq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_push;
        logic is_pop;
        logic is_list;
        logic is_none;
        logic refused;   // push when full, pop or listing when empty
        logic last;      // last flag of the result register
    } dq_sts_t;

endpackage

>>> src/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 32-bit values in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, action, value) takes one transaction:
//   push rear, push front, pop front, pop rear, list forward, list reverse.
//   Output channel (out_valid/out_ready, status, data, last) returns the
//   results. Pushes and pops give one result; a listing gives one result per
//   stored element, last set on the final one. Refused operations (push when
//   full, pop or listing when empty) give a single result with status set
//   and data zero. Action codes 6 and 7 are dropped with no result.
// Timing:
//   One transaction at a time. Push or refusal: result loaded in EXEC, valid
//   in OUT; pop: store read in EXEC, loaded in RD, valid in OUT. A listing
//   runs EXEC (index, store read), RD and OUT for each element, set by the
//   single store read port and the registered RAM output. in_ready returns the
//   cycle after the last result is taken, or after EXEC for an ignored code.
// Reset:
//   rst_n clears head and count, so the queue is empty; store contents are
//   left as they are, only occupied entries are ever read.
// Stall:
//   A result is held in its register, unchanged, until out_ready; nothing
//   further is taken or computed meanwhile.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dq_pkg::ACT_W-1:0]          action,
    input  logic signed [dq_pkg::DATA_W-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dq_pkg::STAT_W-1:0]         status,
    output logic signed [dq_pkg::DATA_W-1:0]  data,
    output logic                              last
);

    dq_pkg::dq_cmd_t cmd;
    dq_pkg::dq_sts_t sts;

    // sequencer: handshakes and per-transaction flow
    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // pointers, count, store and result register
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .action (action),
        .value  (value),
        .status (status),
        .data   (data),
        .last   (last)
    );

endmodule

>>> src/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Ring pointers, element count, element store and the result register.
// ----------------------------------------------------------------------------
module dq_datapath #(
    parameter  int DEPTH = dq_pkg::DEPTH_DEF,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dq_pkg::dq_cmd_t                  cmd,
    output dq_pkg::dq_sts_t                  sts,
    input  logic [dq_pkg::ACT_W-1:0]         action,
    input  logic signed [dq_pkg::DATA_W-1:0] value,
    output logic [dq_pkg::STAT_W-1:0]        status,
    output logic signed [dq_pkg::DATA_W-1:0] data,
    output logic                             last
);

    localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] TOP_IDX = PTR_W'(DEPTH - 1);

    logic [dq_pkg::ACT_W-1:0]         act_reg;
    logic signed [dq_pkg::DATA_W-1:0] val_reg;
    logic [PTR_W-1:0]                 head_reg, head_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [PTR_W-1:0]                 idx_reg;
    logic [dq_pkg::STAT_W-1:0]        status_reg;
    logic signed [dq_pkg::DATA_W-1:0] data_reg;
    logic                             last_reg;

    logic             full, empty;
    logic [CNT_W-1:0] cnt_m1;
    logic [PTR_W-1:0] offset, pos, head_inc;
    logic [PTR_W:0]   sum;
    logic             ram_we;
    logic [dq_pkg::DATA_W-1:0] ram_rdata;

    assign full   = (count_reg == DEPTH_C);
    assign empty  = (count_reg == '0);
    assign cnt_m1 = count_reg - CNT_W'(1);

    // action decode
    assign sts.is_push = (act_reg == dq_pkg::ACT_PUSH_REAR) ||
                         (act_reg == dq_pkg::ACT_PUSH_FRONT);
    assign sts.is_pop  = (act_reg == dq_pkg::ACT_POP_FRONT) ||
                         (act_reg == dq_pkg::ACT_POP_REAR);
    assign sts.is_list = (act_reg == dq_pkg::ACT_LIST_FWD) ||
                         (act_reg == dq_pkg::ACT_LIST_REV);
    assign sts.is_none = !(sts.is_push || sts.is_pop || sts.is_list);
    assign sts.refused = (sts.is_push && full) ||
                         ((sts.is_pop || sts.is_list) && empty);
    assign sts.last    = last_reg;

    // offset from head; count is below DEPTH wherever it is used here
    always_comb
    begin
        case (act_reg)
            dq_pkg::ACT_PUSH_REAR:  offset = count_reg[PTR_W-1:0];
            dq_pkg::ACT_PUSH_FRONT: offset = TOP_IDX;
            dq_pkg::ACT_POP_FRONT:  offset = '0;
            dq_pkg::ACT_POP_REAR:   offset = cnt_m1[PTR_W-1:0];
            dq_pkg::ACT_LIST_FWD:   offset = idx_reg;
            dq_pkg::ACT_LIST_REV:   offset = cnt_m1[PTR_W-1:0] - idx_reg;
            default:                offset = '0;
        endcase
    end

    // ring position: both terms below DEPTH, one compare and subtract
    assign sum = {1'b0, head_reg} + {1'b0, offset};
    assign pos = (sum >= DEPTH_P) ? PTR_W'(sum - DEPTH_P) : sum[PTR_W-1:0];

    assign head_inc = (head_reg == TOP_IDX) ? '0 : head_reg + PTR_W'(1);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.commit)
        begin
            case (act_reg)
                dq_pkg::ACT_PUSH_REAR:
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                dq_pkg::ACT_PUSH_FRONT:
                begin
                    head_next  = pos;
                    count_next = count_reg + CNT_W'(1);
                end
                dq_pkg::ACT_POP_FRONT:
                begin
                    head_next  = head_inc;
                    count_next = cnt_m1;
                end
                dq_pkg::ACT_POP_REAR:
                begin
                    count_next = cnt_m1;
                end
                default:
                begin
                    head_next  = head_reg;
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign ram_we = cmd.commit && sts.is_push;

    dq_ram #(
        .WIDTH (dq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos),
        .wdata (val_reg),
        .re    (cmd.rd_en),
        .raddr (pos),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= '0;
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.capture)
            begin
                act_reg <= action;
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + PTR_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            val_reg <= value;
        end
        if (cmd.load_imm)
        begin
            if (!sts.refused)
            begin
                status_reg <= dq_pkg::ST_OK;
            end
            else if (sts.is_push)
            begin
                status_reg <= dq_pkg::ST_FULL;
            end
            else
            begin
                status_reg <= dq_pkg::ST_EMPTY;
            end
            data_reg <= '0;
            last_reg <= 1'b1;
        end
        else if (cmd.load_mem)
        begin
            status_reg <= dq_pkg::ST_OK;
            data_reg   <= ram_rdata;
            last_reg   <= sts.is_list ? (idx_reg == cnt_m1[PTR_W-1:0]) : 1'b1;
        end
    end

    assign status = status_reg;
    assign data   = data_reg;
    assign last   = last_reg;

endmodule

>>> src/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: takes one transaction, runs it, walks listings one element a time.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  dq_pkg::dq_sts_t sts,
    output dq_pkg::dq_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_RD   = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.is_none)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.refused)
                begin
                    cmd.load_imm = 1'b1;
                    state_next   = S_OUT;
                end
                else if (sts.is_push)
                begin
                    cmd.commit   = 1'b1;
                    cmd.load_imm = 1'b1;
                    state_next   = S_OUT;
                end
                else if (sts.is_pop)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.commit = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.load_mem = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.is_list && !sts.last)
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
